FILE: sv/ias_pkg.sv
// ----------------------------------------------------------------------------
// ias_pkg: shared types and constants for interval activity selection
// Widths of the item fields, store depth and the payload structs.
// ----------------------------------------------------------------------------
package ias_pkg;
  localparam int unsigned MaxIntervals = 1024;
  localparam int unsigned AddrW = $clog2(MaxIntervals);
  localparam int unsigned CntW = AddrW + 1;
  localparam int unsigned TimeW = 31;
  localparam int unsigned KeyW = 2 * TimeW;
  localparam int unsigned SelW = 11;

  typedef struct packed {
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] end_time;
    logic             last_item;
  } in_item_t;

  typedef struct packed {
    logic [SelW-1:0] selected_count;
    logic            overflow;
  } out_item_t;
endpackage

FILE: sv/ias_if.sv
// ----------------------------------------------------------------------------
// ias_if: valid/ready channels for interval activity selection
// One interface per direction; payload carried as a package struct.
// ----------------------------------------------------------------------------
interface ias_in_if (input logic clk);
  import ias_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ias_out_if (input logic clk);
  import ias_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/interval_activity_selection_top.sv
// ----------------------------------------------------------------------------
// interval_activity_selection_top: greedy interval scheduling over a batch
// Loads intervals, heap-sorts them by (end, start) in a memory, then scans.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// in_ch    | in  | start_time[30:0], end_time[30:0], last_item
// out_ch   | out | selected_count[10:0], overflow
//
// Loading takes one item per cycle. After the last item the heap sort runs
// on one read port and one write port: each sift level reads a parent and
// its children, compares, and swaps if a child is larger; each extraction
// swaps the root with the heap tail, and the scan reads the sorted keys in
// order. in ready is low from the last item until the result is taken.
// rst is synchronous and clears the state, count and overflow flag; the
// store needs no clearing. A stalled result holds in the output register.
module interval_activity_selection_top (
  input logic clk,
  input logic rst,
  ias_in_if.sink    in_ch,
  ias_out_if.source out_ch
);
  import ias_pkg::*;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_NEXT   = 4'd1;
  localparam logic [3:0] S_SIFT   = 4'd2;
  localparam logic [3:0] S_RDL    = 4'd3;
  localparam logic [3:0] S_RDR    = 4'd4;
  localparam logic [3:0] S_CMP    = 4'd5;
  localparam logic [3:0] S_WRR    = 4'd6;
  localparam logic [3:0] S_WRC    = 4'd7;
  localparam logic [3:0] S_SWP0   = 4'd8;
  localparam logic [3:0] S_SWP1   = 4'd9;
  localparam logic [3:0] S_SWP2   = 4'd10;
  localparam logic [3:0] S_SWP3   = 4'd11;
  localparam logic [3:0] S_SCAN   = 4'd12;
  localparam logic [3:0] S_SCANC  = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [KeyW-1:0]  mem [MaxIntervals];
  logic [KeyW-1:0]  rd_data;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             wr_en;
  logic [KeyW-1:0]  wr_data;

  logic [3:0]       state;
  logic [CntW-1:0]  count;      // stored intervals
  logic             ovf;
  logic [CntW-1:0]  heap_n;     // active heap size
  logic [CntW-1:0]  build_i;    // next build root + 1
  logic [CntW-1:0]  root;
  logic [CntW-1:0]  child;
  logic             phase_ext;  // sort is in the extraction phase
  logic [KeyW-1:0]  key_r, key_l, key_c;
  logic [CntW-1:0]  idx;
  logic [TimeW-1:0] last_end;
  logic [SelW-1:0]  taken;
  out_item_t        out_data;

  logic [CntW:0]    lchild, rchild, heap_n_x;
  logic             has_right, pick_right;
  logic [KeyW-1:0]  sel_key;
  logic [CntW-1:0]  tail;
  logic             has_room;
  logic [CntW-1:0]  load_n;
  logic             take_it;
  logic [SelW-1:0]  taken_upd;

  // memory, one port per direction, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign in_ch.ready  = (state == S_LOAD);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data  = out_data;

  // heap indexes and child selection
  assign lchild     = {root, 1'b1};
  assign rchild     = lchild + 1'b1;
  assign heap_n_x   = {1'b0, heap_n};
  assign has_right  = rchild < heap_n_x;
  assign pick_right = has_right && (rd_data > key_l);
  assign sel_key    = pick_right ? rd_data : key_l;
  assign tail       = heap_n - 1'b1;

  // load bookkeeping
  assign has_room = count < CntW'(MaxIntervals);
  assign load_n   = has_room ? count + 1'b1 : count;

  // greedy scan step
  assign take_it   = (taken == '0) || (rd_data[TimeW-1:0] >= last_end);
  assign taken_upd = taken + SelW'(take_it);

  // memory port steering
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_addr = '0;
    case (state)
      S_LOAD: begin
        wr_en   = in_ch.valid && has_room;
        wr_addr = count[AddrW-1:0];
        wr_data = {in_ch.data.end_time, in_ch.data.start_time};
      end
      S_SIFT: rd_addr = root[AddrW-1:0];
      S_RDL:  rd_addr = lchild[AddrW-1:0];
      S_RDR:  rd_addr = rchild[AddrW-1:0];
      S_WRR: begin
        wr_en = 1'b1; wr_addr = root[AddrW-1:0]; wr_data = key_c;
      end
      S_WRC: begin
        wr_en = 1'b1; wr_addr = child[AddrW-1:0]; wr_data = key_r;
      end
      S_SWP1: rd_addr = tail[AddrW-1:0];
      S_SWP2: begin
        wr_en = 1'b1; wr_addr = tail[AddrW-1:0]; wr_data = key_r;
      end
      S_SWP3: begin
        wr_en = 1'b1; wr_addr = '0; wr_data = key_l;
      end
      S_SCAN: rd_addr = idx[AddrW-1:0];
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      phase_ext <= 1'b0;
      out_data  <= '0;
    end else begin
      case (state)
        S_LOAD: if (in_ch.valid) begin
          if (has_room) count <= count + 1'b1;
          else ovf <= 1'b1;
          if (in_ch.data.last_item) begin
            heap_n    <= load_n;
            build_i   <= load_n >> 1;
            phase_ext <= 1'b0;
            state     <= S_NEXT;
          end
        end
        // sift finished: next build root, next extraction, or scan
        S_NEXT: begin
          if (!phase_ext && build_i != '0) begin
            root    <= build_i - 1'b1;
            build_i <= build_i - 1'b1;
            state   <= S_SIFT;
          end else if (heap_n > CntW'(1)) begin
            phase_ext <= 1'b1;
            state     <= S_SWP0;
          end else begin
            idx      <= '0;
            taken    <= '0;
            last_end <= '0;
            state    <= S_SCAN;
          end
        end
        // sift-down: read root, left, right, compare, swap
        S_SIFT: begin
          if (lchild >= heap_n_x) state <= S_NEXT;
          else state <= S_RDL;
        end
        S_RDL: begin
          key_r <= rd_data;
          state <= S_RDR;
        end
        S_RDR: begin
          key_l <= rd_data;
          state <= S_CMP;
        end
        S_CMP: begin
          key_c <= sel_key;
          child <= pick_right ? rchild[CntW-1:0] : lchild[CntW-1:0];
          if (key_r >= sel_key) state <= S_NEXT;
          else state <= S_WRR;
        end
        S_WRR: state <= S_WRC;
        S_WRC: begin
          root  <= child;
          state <= S_SIFT;
        end
        // extraction: swap max at the root with the heap tail
        S_SWP0: state <= S_SWP1;
        S_SWP1: begin
          key_r <= rd_data;
          state <= S_SWP2;
        end
        S_SWP2: begin
          key_l <= rd_data;
          state <= S_SWP3;
        end
        S_SWP3: begin
          heap_n <= tail;
          root   <= '0;
          state  <= S_SIFT;
        end
        // greedy scan over the sorted store
        S_SCAN: state <= S_SCANC;
        S_SCANC: begin
          if (take_it) begin
            taken    <= taken_upd;
            last_end <= rd_data[KeyW-1:TimeW];
          end
          idx <= idx + 1'b1;
          if (idx + 1'b1 == count) begin
            out_data.selected_count <= taken_upd;
            out_data.overflow       <= ovf;
            state                   <= S_OUT;
          end else begin
            state <= S_SCAN;
          end
        end
        // hold the result until taken, then start a new batch
        S_OUT: if (out_ch.ready) begin
          count <= '0;
          ovf   <= 1'b0;
          state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

FILE: sv/ias_checker.sv
// ----------------------------------------------------------------------------
// ias_checker: port-level checks for interval activity selection
// Handshake and batch behavior seen from the top level's ports.
// ----------------------------------------------------------------------------
module ias_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready) else $error("ready after last");
  a_no_load_with_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("loading while result pending");
endmodule

bind interval_activity_selection_top ias_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.data.last_item),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);

FILE: sim/interval_activity_selection_top_test.sv
// ----------------------------------------------------------------------------
// interval_activity_selection_top_test: batch interval scheduling testbench
// Sends batches of intervals with random idling on both channels. Each
// result is checked against a greedy count taken over the batch sorted by
// (end, start). Also covers store overflow and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interval_activity_selection_top_test;
  import ias_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned LongHold = 3000;
  localparam int unsigned TailWait = 64;

  typedef logic [KeyW-1:0] key_t;

  // Keeps the current batch and the counts still to come from the block
  class selection_scoreboard;
    key_t      batch_keys[$];
    logic      batch_dropped;
    out_item_t pending_counts[$];
    int        mismatches;

    function new();
      batch_dropped = 1'b0;
      mismatches = 0;
    endfunction

    // Greedy count over keys sorted by (end, start)
    function logic [SelW-1:0] greedy_count(key_t keys[$]);
      int unsigned taken;
      logic [TimeW-1:0] last_end;
      taken = 0;
      last_end = '0;
      keys.sort();
      foreach (keys[i]) begin
        if (i == 0 || keys[i][TimeW-1:0] >= last_end) begin
          taken++;
          last_end = keys[i][KeyW-1:TimeW];
        end
      end
      return taken[SelW-1:0];
    endfunction

    function void note_interval(in_item_t item);
      out_item_t res;
      if (batch_keys.size() < MaxIntervals) begin
        batch_keys = {batch_keys, key_t'({item.end_time, item.start_time})};
      end else begin
        batch_dropped = 1'b1;
      end
      if (item.last_item) begin
        res.selected_count = greedy_count(batch_keys);
        res.overflow = batch_dropped;
        pending_counts = {pending_counts, res};
        batch_keys.delete();
        batch_dropped = 1'b0;
      end
    endfunction

    function void check_count(out_item_t got);
      out_item_t want;
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected result count=%0d overflow=%0b",
                   got.selected_count, got.overflow);
        end
        return;
      end
      want = pending_counts.pop_front();
      if (got.selected_count !== want.selected_count || got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: count exp %0d got %0d, overflow exp %0b got %0b",
                   want.selected_count, got.selected_count, want.overflow, got.overflow);
        end
      end
    endfunction

    function int pending();
      return pending_counts.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int unsigned cycles;
  bit no_idle;
  bit hold_request;

  ias_in_if  in_ch (clk);
  ias_out_if out_ch (clk);

  interval_activity_selection_top uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  selection_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one interval after a random gap; returns once it is accepted
  task automatic send_interval(logic [TimeW-1:0] s, logic [TimeW-1:0] e, logic last);
    int unsigned gap;
    logic rdy;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{start_time: s, end_time: e, last_item: last};
    do begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
    end while (!rdy);
    sb.note_interval(in_ch.data);
  endtask

  // Random interval, mostly in a narrow window so that overlaps are common
  task automatic send_random(logic last);
    logic [TimeW-1:0] s;
    logic [TimeW-1:0] e;
    case ($urandom_range(0, 9))
      0: begin
        s = TimeW'($urandom());
        e = TimeW'($urandom());
      end
      1: begin
        e = TimeW'($urandom_range(0, 200));
        s = TimeW'(e + $urandom_range(0, 20));
      end
      2: begin
        s = TimeW'(31'h7FFF_FFFF - $urandom_range(0, 50));
        e = TimeW'(31'h7FFF_FFFF - $urandom_range(0, 10));
      end
      default: begin
        s = TimeW'($urandom_range(0, 200));
        e = TimeW'(s + $urandom_range(0, 30));
      end
    endcase
    send_interval(s, e, last);
  endtask

  // Result side: random stall per item, one long hold-off on request
  initial begin
    int unsigned stall;
    logic got;
    out_item_t res;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        stall = LongHold;
        hold_request = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        got = out_ch.valid;
        res = out_ch.data;
        @(posedge clk);
      end while (!got);
      sb.check_count(res);
    end
  end

  // Stimulus
  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned wait_cycles;
    bit overflow_done;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cycles = 0;
    no_idle = 1'b0;
    hold_request = 1'b0;
    overflow_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single interval, extremes of the time range
    send_interval('0, '0, 1'b1);
    send_interval(31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    send_interval('0, 31'h7FFF_FFFF, 1'b0);
    send_interval(31'h7FFF_FFFF, '0, 1'b1);
    // touching intervals are all taken
    send_interval(10, 20, 1'b0);
    send_interval(20, 30, 1'b0);
    send_interval(30, 30, 1'b1);
    // end before start, and equal ends broken by start
    send_interval(50, 40, 1'b0);
    send_interval(35, 45, 1'b0);
    send_interval(5, 45, 1'b0);
    send_interval(45, 45, 1'b0);
    send_interval(44, 45, 1'b1);
    // nested and overlapping intervals
    send_interval(0, 100, 1'b0);
    send_interval(10, 20, 1'b0);
    send_interval(15, 25, 1'b0);
    send_interval(20, 90, 1'b0);
    send_interval(25, 30, 1'b0);
    send_interval(99, 100, 1'b1);
    // alternating bit patterns
    send_interval(31'h5555_5555, 31'h2AAA_AAAA, 1'b0);
    send_interval(31'h2AAA_AAAA, 31'h5555_5555, 1'b1);

    // Random batches, with a long output hold-off early on
    sent = 0;
    hold_request = 1'b1;
    while (sent < 1330) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if (!overflow_done && sent > 300) begin
        // store full: extra intervals, the last one among them, are dropped
        n = MaxIntervals + 1 + $urandom_range(0, 3);
        no_idle = 1'b1;
        overflow_done = 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 3);
      end else begin
        n = $urandom_range(1, 40);
      end
      for (int unsigned i = 0; i < n; i++) begin
        send_random(i == n - 1);
      end
      sent += n;
      // let the block drain completely now and then
      if ($urandom_range(0, 9) == 0) begin
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    // Drain
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (TailWait) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/ias_pkg.sv
sv/ias_if.sv
sv/interval_activity_selection_top.sv
sv/ias_checker.sv
sim/interval_activity_selection_top_test.sv
